// ===== sv/pixel_channel_format_convert_defines.svh =====
// Assertion macros for the pixel channel format converter.
`ifndef PIXEL_CHANNEL_FORMAT_CONVERT_DEFINES_SVH
`define PIXEL_CHANNEL_FORMAT_CONVERT_DEFINES_SVH

`ifndef SYNTHESIS
`define PCFC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PCFC_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PCFC_ASSERT(lbl, clk, rst, prop, msg)
`define PCFC_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

// ===== sv/pcfc_pkg.sv =====
// Shared types and constants of the pixel channel format converter.
package pcfc_pkg;

   localparam int WEIGHT_W  = 11;
   localparam int CHCODE_W  = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = WEIGHT_W;

   // channel count codes
   localparam logic [CHCODE_W-1:0] CH_GRAY       = 3'd1;
   localparam logic [CHCODE_W-1:0] CH_GRAY_ALPHA = 3'd2;
   localparam logic [CHCODE_W-1:0] CH_RGB        = 3'd3;
   localparam logic [CHCODE_W-1:0] CH_RGBA       = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_IN_CHANNELS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_COLOR    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_ALPHA    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT_RED   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT_GREEN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT_BLUE  = 3'd5;

   // register reset values
   localparam logic [WEIGHT_W-1:0] WEIGHT_RED_RST   = 11'd307;
   localparam logic [WEIGHT_W-1:0] WEIGHT_GREEN_RST = 11'd604;
   localparam logic [WEIGHT_W-1:0] WEIGHT_BLUE_RST  = 11'd113;

   typedef struct packed {
      logic [CHCODE_W-1:0] in_channels;
      logic                out_color;
      logic                out_alpha;
      logic [WEIGHT_W-1:0] weight_red;
      logic [WEIGHT_W-1:0] weight_green;
      logic [WEIGHT_W-1:0] weight_blue;
   } cfg_type;

   typedef struct packed {
      logic s1;
      logic s2;
   } stage_en_type;

endpackage

// ===== sv/pcfc_csr.sv =====
// Configuration register file of the pixel channel format converter.
module pcfc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pcfc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pcfc_pkg::CSR_DATA_W-1:0]     csr_data,
   output pcfc_pkg::cfg_type                   cfg
);
   import pcfc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_IN_CHANNELS:  cfg_in.in_channels  = csr_data[CHCODE_W-1:0];
            REG_OUT_COLOR:    cfg_in.out_color    = csr_data[0];
            REG_OUT_ALPHA:    cfg_in.out_alpha    = csr_data[0];
            REG_WEIGHT_RED:   cfg_in.weight_red   = csr_data[WEIGHT_W-1:0];
            REG_WEIGHT_GREEN: cfg_in.weight_green = csr_data[WEIGHT_W-1:0];
            REG_WEIGHT_BLUE:  cfg_in.weight_blue  = csr_data[WEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.in_channels  <= CH_RGBA;
         cfg_ff.out_color    <= 1'b0;
         cfg_ff.out_alpha    <= 1'b0;
         cfg_ff.weight_red   <= WEIGHT_RED_RST;
         cfg_ff.weight_green <= WEIGHT_GREEN_RST;
         cfg_ff.weight_blue  <= WEIGHT_BLUE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== sv/pcfc_datapath.sv =====
// Two-stage datapath: input register, then weighted sum, rounding and format select into the result register.
module pcfc_datapath #(
   parameter int CHANNEL_BITS     = 8,
   parameter int WEIGHT_FRAC_BITS = 10
) (
   input  logic                              clock,
   input  pcfc_pkg::stage_en_type            en,
   input  pcfc_pkg::cfg_type                 cfg,
   input  logic [CHANNEL_BITS-1:0]           chan0,
   input  logic [CHANNEL_BITS-1:0]           chan1,
   input  logic [CHANNEL_BITS-1:0]           chan2,
   input  logic [CHANNEL_BITS-1:0]           chan3,
   output logic [CHANNEL_BITS-1:0]           out0,
   output logic [CHANNEL_BITS-1:0]           out1,
   output logic [CHANNEL_BITS-1:0]           out2,
   output logic [CHANNEL_BITS-1:0]           out3,
   output logic [pcfc_pkg::CHCODE_W-1:0]     out_count
);
   import pcfc_pkg::*;

   localparam int PROD_W = CHANNEL_BITS + WEIGHT_W;
   localparam int SUM_W  = PROD_W + 2;
   localparam int RND_W  = SUM_W + 1;
   localparam logic [CHANNEL_BITS-1:0] CHAN_MAX = {CHANNEL_BITS{1'b1}};
   localparam logic [RND_W-1:0] HALF = RND_W'(1) << (WEIGHT_FRAC_BITS - 1);

   // input stage
   logic [CHANNEL_BITS-1:0] c0_ff, c1_ff, c2_ff, c3_ff;

   // result stage
   logic                    in_color, in_alpha;
   logic [CHANNEL_BITS-1:0] red, green, blue, alpha;
   logic [PROD_W-1:0]       pr, pg, pb;
   logic [SUM_W-1:0]        sum;
   logic [RND_W-1:0]        rnd;
   logic [CHANNEL_BITS-1:0] luma, gray;
   logic [CHANNEL_BITS-1:0] o0_in, o1_in, o2_in, o3_in;
   logic [CHCODE_W-1:0]     cnt_in;
   logic [CHANNEL_BITS-1:0] o0_ff, o1_ff, o2_ff, o3_ff;
   logic [CHCODE_W-1:0]     cnt_ff;

   always_ff @(posedge clock) begin
      if (en.s1) begin
         c0_ff <= chan0;
         c1_ff <= chan1;
         c2_ff <= chan2;
         c3_ff <= chan3;
      end
   end

   always_comb begin
      in_color = (cfg.in_channels >= CH_RGB);
      in_alpha = (cfg.in_channels == CH_GRAY_ALPHA) || (cfg.in_channels >= CH_RGBA);
      red   = c0_ff;
      green = in_color ? c1_ff : c0_ff;
      blue  = in_color ? c2_ff : c0_ff;
      if (in_alpha) alpha = in_color ? c3_ff : c1_ff;
      else          alpha = CHAN_MAX;
      pr   = PROD_W'(red) * PROD_W'(cfg.weight_red);
      pg   = PROD_W'(green) * PROD_W'(cfg.weight_green);
      pb   = PROD_W'(blue) * PROD_W'(cfg.weight_blue);
      sum  = SUM_W'(pr) + SUM_W'(pg) + SUM_W'(pb);
      rnd  = (RND_W'(sum) + HALF) >> WEIGHT_FRAC_BITS;
      luma = (rnd > RND_W'(CHAN_MAX)) ? CHAN_MAX : rnd[CHANNEL_BITS-1:0];
      gray = in_color ? luma : red;
      o0_in = '0;
      o1_in = '0;
      o2_in = '0;
      o3_in = '0;
      case ({cfg.out_color, cfg.out_alpha})
         2'b00: begin
            o0_in  = gray;
            cnt_in = CH_GRAY;
         end
         2'b01: begin
            o0_in  = gray;
            o1_in  = alpha;
            cnt_in = CH_GRAY_ALPHA;
         end
         2'b10: begin
            o0_in  = red;
            o1_in  = green;
            o2_in  = blue;
            cnt_in = CH_RGB;
         end
         default: begin
            o0_in  = red;
            o1_in  = green;
            o2_in  = blue;
            o3_in  = alpha;
            cnt_in = CH_RGBA;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         o0_ff  <= o0_in;
         o1_ff  <= o1_in;
         o2_ff  <= o2_in;
         o3_ff  <= o3_in;
         cnt_ff <= cnt_in;
      end
   end

   assign out0      = o0_ff;
   assign out1      = o1_ff;
   assign out2      = o2_ff;
   assign out3      = o3_ff;
   assign out_count = cnt_ff;

endmodule

// ===== sv/pixel_channel_format_convert.sv =====
// Pixel channel format converter: gray or color in, gray or color out, alpha optional.
// Two register stages, input then result; an accepted word passes both and is offered on rsp_.
// Throughput: one word per cycle unless rsp_ stalls; the registers advance as one pipeline.
// A stalled result holds its register; the input register fills behind it, then holds.
// Reset clears both stage valid bits and loads the register defaults.
`include "pixel_channel_format_convert_defines.svh"

module pixel_channel_format_convert #(
   parameter int CHANNEL_BITS     = 8,
   parameter int WEIGHT_FRAC_BITS = 10,
   localparam int IN_W  = ((4 * CHANNEL_BITS + 7) / 8) * 8,
   localparam int OUT_W = ((4 * CHANNEL_BITS + 3 + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [IN_W-1:0]                    req_tdata,   // chan0, chan1, chan2, chan3
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [OUT_W-1:0]                   rsp_tdata,   // out0, out1, out2, out3, out_count
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pcfc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pcfc_pkg::CSR_DATA_W-1:0]    csr_data
);
   import pcfc_pkg::*;

   cfg_type                 cfg;
   stage_en_type            en;
   logic                    v1_ff, v2_ff;
   logic                    v1_in, v2_in;
   logic [CHANNEL_BITS-1:0] out0, out1, out2, out3;
   logic [CHCODE_W-1:0]     out_count;

   pcfc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   always_comb begin
      en.s2 = !v2_ff || rsp_tready;
      en.s1 = !v1_ff || en.s2;
      v1_in = en.s1 ? req_tvalid : v1_ff;
      v2_in = en.s2 ? v1_ff : v2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   pcfc_datapath #(
      .CHANNEL_BITS     (CHANNEL_BITS),
      .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .en        (en),
      .cfg       (cfg),
      .chan0     (req_tdata[CHANNEL_BITS-1:0]),
      .chan1     (req_tdata[2*CHANNEL_BITS-1:CHANNEL_BITS]),
      .chan2     (req_tdata[3*CHANNEL_BITS-1:2*CHANNEL_BITS]),
      .chan3     (req_tdata[4*CHANNEL_BITS-1:3*CHANNEL_BITS]),
      .out0      (out0),
      .out1      (out1),
      .out2      (out2),
      .out3      (out3),
      .out_count (out_count)
   );

   assign req_tready = en.s1;
   assign rsp_tvalid = v2_ff;
   assign rsp_tdata  = OUT_W'({out_count, out3, out2, out1, out0});

   `PCFC_ASSERT(a_accept_lands, clock, reset, (req_tvalid && req_tready) |=> v1_ff,
      "accepted word missing from input stage")
   `PCFC_ASSERT(a_count_format, clock, reset,
      rsp_tvalid |-> (out_count == (cfg.out_color ? (cfg.out_alpha ? CH_RGBA : CH_RGB)
         : (cfg.out_alpha ? CH_GRAY_ALPHA : CH_GRAY))),
      "channel count does not match output format")
   `PCFC_ASSERT(a_gray_zero, clock, reset,
      (rsp_tvalid && !cfg.out_color) |-> (out2 == '0 && out3 == '0),
      "gray output has nonzero color channels")
   `PCFC_ASSERT(a_empty_drain, clock, reset, (!v1_ff && !v2_ff) |=> !rsp_tvalid,
      "result offered from an empty pipeline")
   `PCFC_ASSERT_NR(a_reset_clear, clock, reset |=> (!rsp_tvalid && !v1_ff),
      "pipeline not cleared by reset")

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for pixel_channel_format_convert: directed table, then random phases.
`timescale 1ns / 100ps

module tb_top;
   import pcfc_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int MAX_REPORTS   = 10;
   localparam int FRAC_BITS     = 10;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_WORDS   = 95;
   localparam int SETTLE_CYCLES = 8;

   localparam logic [7:0] FULL_SCALE = 8'hFF;

   localparam logic [CHCODE_W-1:0] CH_RESERVED_0 = 3'd0;
   localparam logic [CHCODE_W-1:0] CH_RESERVED_5 = 3'd5;
   localparam logic [CHCODE_W-1:0] CH_RESERVED_6 = 3'd6;
   localparam logic [CHCODE_W-1:0] CH_RESERVED_7 = 3'd7;

   localparam logic [WEIGHT_W-1:0] W_ZERO = 11'd0;
   localparam logic [WEIGHT_W-1:0] W_ONE  = 11'd1024;
   localparam logic [WEIGHT_W-1:0] W_MAX  = 11'd2047;

   typedef struct packed {
      logic [4:0] pad;
      logic [2:0] count;
      logic [7:0] out3;
      logic [7:0] out2;
      logic [7:0] out1;
      logic [7:0] out0;
   } pixel_out_type;

   typedef struct packed {
      cfg_type     cfg;
      logic [31:0] word;
      logic        known;
      logic [39:0] rsp;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata = '0;   // chan0, chan1, chan2, chan3
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [39:0]           rsp_tdata;        // out0, out1, out2, out3, out_count
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   cfg_type          shadow_cfg;
   pixel_out_type    expected_px[$];
   directed_row_type plan[$];
   int               stall_pct = 18;
   int               errors = 0;
   int               words_seen = 0;
   int               pixels_sent = 0;
   int               cfg_batches = 0;
   int               cycles = 0;

   pixel_channel_format_convert dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic pixel_out_type convert_pixel(logic [31:0] word);
      logic [7:0]          c0, c1, c2, c3, r, g, b, a;
      logic [CHCODE_W-1:0] n;
      logic                color_in, alpha_in;
      logic [31:0]         acc;
      pixel_out_type       px;
      {c3, c2, c1, c0} = word;
      n = shadow_cfg.in_channels;
      if (n < CH_GRAY) n = CH_GRAY;
      if (n > CH_RGBA) n = CH_RGBA;
      color_in = (n >= CH_RGB);
      alpha_in = (n == CH_GRAY_ALPHA) || (n == CH_RGBA);
      r = c0;
      g = color_in ? c1 : c0;
      b = color_in ? c2 : c0;
      a = alpha_in ? (color_in ? c3 : c1) : FULL_SCALE;
      px = '0;
      if (shadow_cfg.out_color) begin
         px.out0 = r;
         px.out1 = g;
         px.out2 = b;
         if (shadow_cfg.out_alpha) px.out3 = a;
         px.count = shadow_cfg.out_alpha ? CH_RGBA : CH_RGB;
      end else begin
         if (color_in) begin
            acc = 32'(r) * 32'(shadow_cfg.weight_red) + 32'(g) * 32'(shadow_cfg.weight_green)
                + 32'(b) * 32'(shadow_cfg.weight_blue) + (32'd1 << (FRAC_BITS - 1));
            acc = acc >> FRAC_BITS;
            px.out0 = (acc > 32'(FULL_SCALE)) ? FULL_SCALE : acc[7:0];
         end else begin
            px.out0 = c0;
         end
         if (shadow_cfg.out_alpha) px.out1 = a;
         px.count = shadow_cfg.out_alpha ? CH_GRAY_ALPHA : CH_GRAY;
      end
      return px;
   endfunction

   function automatic logic [7:0] rand_chan();
      case ($urandom_range(9))
         0: return 8'h00;
         1: return FULL_SCALE;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [WEIGHT_W-1:0] rand_weight();
      case ($urandom_range(7))
         0: return W_ZERO;
         1: return W_MAX;
         2: return W_ONE;
         default: return 11'($urandom_range(2047));
      endcase
   endfunction

   task automatic send_word(logic [31:0] word, logic known, logic [39:0] rsp);
      while ($urandom_range(99) < stall_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      expected_px.push_back(known ? pixel_out_type'(rsp) : convert_pixel(word));
      pixels_sent++;
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_IN_CHANNELS:  shadow_cfg.in_channels  = data[CHCODE_W-1:0];
         REG_OUT_COLOR:    shadow_cfg.out_color    = data[0];
         REG_OUT_ALPHA:    shadow_cfg.out_alpha    = data[0];
         REG_WEIGHT_RED:   shadow_cfg.weight_red   = data;
         REG_WEIGHT_GREEN: shadow_cfg.weight_green = data;
         REG_WEIGHT_BLUE:  shadow_cfg.weight_blue  = data;
         default: ;
      endcase
   endtask

   // drain the pipeline, then program whatever differs and, if asked, write a spare register index
   task automatic apply_cfg(cfg_type c, logic poke_spare);
      if (c == shadow_cfg && !poke_spare) return;
      req_tvalid <= 1'b0;
      while (expected_px.size() != 0) @(posedge clock);
      if (c.in_channels != shadow_cfg.in_channels)
         write_reg(REG_IN_CHANNELS, CSR_DATA_W'(c.in_channels));
      if (c.out_color != shadow_cfg.out_color)
         write_reg(REG_OUT_COLOR, CSR_DATA_W'(c.out_color));
      if (c.out_alpha != shadow_cfg.out_alpha)
         write_reg(REG_OUT_ALPHA, CSR_DATA_W'(c.out_alpha));
      if (c.weight_red != shadow_cfg.weight_red) write_reg(REG_WEIGHT_RED, c.weight_red);
      if (c.weight_green != shadow_cfg.weight_green) write_reg(REG_WEIGHT_GREEN, c.weight_green);
      if (c.weight_blue != shadow_cfg.weight_blue) write_reg(REG_WEIGHT_BLUE, c.weight_blue);
      if (poke_spare)
         write_reg(CSR_IDX_W'(REG_WEIGHT_BLUE + $urandom_range(1, 2)), 11'($urandom_range(2047)));
      csr_valid <= 1'b0;
      cfg_batches++;
   endtask

   always @(posedge clock) begin
      pixel_out_type got, want;
      string         diff;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_px.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS) $display("unexpected output word %h", got);
         end else begin
            want = expected_px.pop_front();
            diff = "";
            if (got.out0 !== want.out0) diff = {diff, " out0"};
            if (got.out1 !== want.out1) diff = {diff, " out1"};
            if (got.out2 !== want.out2) diff = {diff, " out2"};
            if (got.out3 !== want.out3) diff = {diff, " out3"};
            if (got.count !== want.count) diff = {diff, " out_count"};
            if (got.pad !== want.pad) diff = {diff, " padding"};
            if (diff != "") begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("word %0d mismatch in%s: expected %h actual %h",
                           words_seen, diff, want, got);
            end
         end
         words_seen++;
      end
   end

   initial begin
      cfg_type          c;
      cfg_type          dflt;
      directed_row_type row;
      int               n_directed;

      dflt = '{CH_RGBA, 1'b0, 1'b0, WEIGHT_RED_RST, WEIGHT_GREEN_RST, WEIGHT_BLUE_RST};
      shadow_cfg = dflt;

      c = dflt;
      plan.push_back('{c, 32'hFFFFFFFF, 1'b1, 40'h01_00_00_00_FF});
      plan.push_back('{c, 32'h00000000, 1'b1, 40'h01_00_00_00_00});
      plan.push_back('{c, 32'h5A332211, 1'b0, 40'h0});
      c.out_color = 1'b1; c.out_alpha = 1'b1;
      plan.push_back('{c, 32'h5A332211, 1'b1, 40'h04_5A_33_22_11});
      c.out_alpha = 1'b0;
      plan.push_back('{c, 32'h5A332211, 1'b1, 40'h03_00_33_22_11});
      c.in_channels = CH_RGB; c.out_alpha = 1'b1;
      plan.push_back('{c, 32'h5A332211, 1'b1, 40'h04_FF_33_22_11});
      c.out_color = 1'b0;
      plan.push_back('{c, 32'h5A332211, 1'b0, 40'h0});
      c.in_channels = CH_GRAY; c.out_color = 1'b1; c.out_alpha = 1'b0;
      plan.push_back('{c, 32'hDDCCBBA7, 1'b1, 40'h03_00_A7_A7_A7});
      c.out_color = 1'b0; c.out_alpha = 1'b1;
      plan.push_back('{c, 32'hDDCCBBA7, 1'b1, 40'h02_00_00_FF_A7});
      c.in_channels = CH_GRAY_ALPHA;
      plan.push_back('{c, 32'hDDCCBBA7, 1'b1, 40'h02_00_00_BB_A7});
      c.out_color = 1'b1;
      plan.push_back('{c, 32'hDDCCBBA7, 1'b1, 40'h04_BB_A7_A7_A7});
      c.out_color = 1'b0; c.out_alpha = 1'b0;
      plan.push_back('{c, 32'hDDCCBBA7, 1'b1, 40'h01_00_00_00_A7});
      c.in_channels = CH_RESERVED_0; c.out_color = 1'b1; c.out_alpha = 1'b1;
      plan.push_back('{c, 32'hDDCCBBA7, 1'b1, 40'h04_FF_A7_A7_A7});
      c.in_channels = CH_RESERVED_5;
      plan.push_back('{c, 32'hDDCCBBA7, 1'b1, 40'h04_DD_CC_BB_A7});
      c.in_channels = CH_RESERVED_6; c.out_color = 1'b0; c.out_alpha = 1'b0;
      plan.push_back('{c, 32'hDDCCBBA7, 1'b0, 40'h0});
      c.in_channels = CH_RESERVED_7; c.out_color = 1'b1;
      plan.push_back('{c, 32'hDDCCBBA7, 1'b1, 40'h03_00_CC_BB_A7});
      c = '{CH_RGBA, 1'b0, 1'b1, W_MAX, W_MAX, W_MAX};
      plan.push_back('{c, 32'h80404040, 1'b1, 40'h02_00_00_80_FF});
      c.weight_red = W_ZERO; c.weight_green = W_ZERO; c.weight_blue = W_ZERO;
      plan.push_back('{c, 32'h80FFFFFF, 1'b1, 40'h02_00_00_80_00});
      c = '{CH_RGB, 1'b0, 1'b0, W_ONE, W_ZERO, W_ZERO};
      plan.push_back('{c, 32'h000000C3, 1'b1, 40'h01_00_00_00_C3});
      c.weight_red = 11'd3;
      plan.push_back('{c, 32'h000000FF, 1'b0, 40'h0});
      c.weight_red = 11'd2;
      plan.push_back('{c, 32'h000000FF, 1'b0, 40'h0});
      c = '{CH_RGB, 1'b0, 1'b0, W_ONE, W_ONE, W_ONE};
      plan.push_back('{c, 32'h00FFFFFF, 1'b1, 40'h01_00_00_00_FF});
      plan.push_back('{dflt, 32'h12345678, 1'b0, 40'h0});

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         row = plan[i];
         apply_cfg(row.cfg, 1'b0);
         send_word(row.word, row.known, row.rsp);
      end
      n_directed = pixels_sent;

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         c.in_channels  = (p < 8) ? CHCODE_W'(p) : CHCODE_W'($urandom_range(7));
         c.out_color    = 1'($urandom_range(1));
         c.out_alpha    = 1'($urandom_range(1));
         c.weight_red   = rand_weight();
         c.weight_green = rand_weight();
         c.weight_blue  = rand_weight();
         apply_cfg(c, (p % 3) == 1);
         // hold both sides busy for a long stretch
         stall_pct = (p == 4 || p == 5) ? 0 : 18;
         for (int k = 0; k < PHASE_WORDS; k++)
            send_word({rand_chan(), rand_chan(), rand_chan(), rand_chan()}, 1'b0, 40'h0);
      end

      req_tvalid <= 1'b0;
      while (expected_px.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d pixels (%0d from the directed table) over %0d register settings",
               pixels_sent, n_directed, cfg_batches);
      $display("checked %0d output words, %0d mismatches", words_seen, errors);
      if (errors == 0 && expected_px.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

// ===== pixel_channel_format_convert.f =====
+incdir+sv
sv/pcfc_pkg.sv
sv/pcfc_csr.sv
sv/pcfc_datapath.sv
sv/pixel_channel_format_convert.sv
dv/tb_top.sv
